FILE: design/tlr_pkg.sv
// ----------------------------------------------------------------------------
// tlr_pkg
// Shared types and constants for the trie lexeme recogniser: the command
// passed from the front end to the back end, and the result group.
// ----------------------------------------------------------------------------
`default_nettype none

package tlr_pkg;

  localparam int NODES_DEFAULT     = 256;
  localparam int KIND_BITS_DEFAULT = 4;
  localparam int CH_W              = 8;
  localparam int KIND_W            = 4;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DETECT = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CH_W-1:0]   ch;
    logic              last;
    logic [KIND_W-1:0] kind;
  } cmd_t;

  typedef struct packed {
    logic              done;
    logic              matched;
    logic [KIND_W-1:0] result_kind;
    logic              store_full;
  } res_t;

endpackage

`default_nettype wire

FILE: design/trie_lexeme_recognizer.sv
// ----------------------------------------------------------------------------
// trie_lexeme_recognizer
// Keyword trie: insert and detect words one byte per transfer.
// ----------------------------------------------------------------------------
// usage
//   input: a transfer is taken at a rising edge with start high and busy low;
//   op, ch, last and kind go with it. op selects insert or detect per byte,
//   last closes the word. empty words are not supported.
//   result: one per word, on its last byte. done is high for exactly one
//   cycle with matched, result_kind and store_full; the receiver cannot
//   stall, so a result must be taken in that cycle.
//   timing: for each byte the back end first reads the transition store,
//   then follows or allocates; the next read address depends on that entry,
//   so the walker takes a new byte only when done with the last one. the
//   result is registered from the entry read for the last byte.
//   a two-entry queue decouples the input side from the walker.
//   reset: rst clears control state, then the transition store is swept one
//   entry per cycle, all NODES*256 entries (65536 by default), with busy high.
// ----------------------------------------------------------------------------
`default_nettype none

module trie_lexeme_recognizer #(
  parameter int NODES     = tlr_pkg::NODES_DEFAULT,
  parameter int KIND_BITS = tlr_pkg::KIND_BITS_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        op,
  input  wire logic [tlr_pkg::CH_W-1:0]    ch,
  input  wire logic                        last,
  input  wire logic [tlr_pkg::KIND_W-1:0]  kind,
  output logic                             done,
  output logic                             matched,
  output logic [tlr_pkg::KIND_W-1:0]       result_kind,
  output logic                             store_full
);

  import tlr_pkg::*;

  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;
  logic clearing;
  res_t res;

  tlr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .op      (op),
    .ch      (ch),
    .last    (last),
    .kind    (kind),
    .clearing(clearing),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  tlr_back #(
    .NODES    (NODES),
    .KIND_BITS(KIND_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .clearing(clearing),
    .res     (res)
  );

  assign done        = res.done;
  assign matched     = res.matched;
  assign result_kind = res.result_kind;
  assign store_full  = res.store_full;

endmodule

`default_nettype wire

FILE: design/tlr_ram.sv
// ----------------------------------------------------------------------------
// tlr_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tlr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: design/tlr_front.sv
// ----------------------------------------------------------------------------
// tlr_front
// Command front end: takes transfers in, packs them into commands and holds
// them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tlr_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      op,
  input  wire logic [tlr_pkg::CH_W-1:0]  ch,
  input  wire logic                      last,
  input  wire logic [tlr_pkg::KIND_W-1:0] kind,
  input  wire logic                      clearing,
  output logic                           q_valid,
  output tlr_pkg::cmd_t                  q_cmd,
  input  wire logic                      q_pop
);

  import tlr_pkg::*;

  cmd_t       slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.op   = op ? OP_DETECT : OP_INSERT;
    cmd_in.ch   = ch;
    cmd_in.last = last;
    cmd_in.kind = kind;
  end

  assign busy    = (count == 2'd2) || clearing;
  assign push    = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_cmd   = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        slots[wptr] <= cmd_in;
        wptr        <= ~wptr;
      end
      if (q_pop) begin
        rptr <= ~rptr;
      end
      if (push && !q_pop) begin
        count <= count + 2'd1;
      end else if (!push && q_pop) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/tlr_back.sv
// ----------------------------------------------------------------------------
// tlr_back
// Trie walker: clears the transition store after reset, then per command
// reads one entry, follows/allocates a transition or fails; reports per word.
// ----------------------------------------------------------------------------
`default_nettype none

module tlr_back #(
  parameter int NODES     = tlr_pkg::NODES_DEFAULT,
  parameter int KIND_BITS = tlr_pkg::KIND_BITS_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  tlr_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               clearing,
  output tlr_pkg::res_t      res
);

  import tlr_pkg::*;

  localparam int NB    = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int AW    = NB + CH_W;
  localparam int DEPTH = NODES * (1 << CH_W);
  localparam int EW    = 2 + KIND_BITS + NB;
  localparam logic [NB:0]   NodesMax = (NB + 1)'(NODES);
  localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL
  } state_t;

  state_t                state;
  logic [AW-1:0]         clr_addr;
  logic [NB:0]           nodes_used;
  logic [NB-1:0]         current_node;
  logic                  word_failed;
  logic                  last_end_mark;
  logic [KIND_BITS-1:0]  last_kind;

  logic [NB:0]           nodes_used_next;
  logic [NB-1:0]         current_node_next;
  logic                  word_failed_next;
  logic                  last_end_mark_next;
  logic [KIND_BITS-1:0]  last_kind_next;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [EW-1:0]         wdata;
  logic                  re;
  logic [AW-1:0]         raddr;
  logic [EW-1:0]         rdata;

  logic                  ent_valid;
  logic                  ent_end;
  logic [KIND_BITS-1:0]  ent_kind;
  logic [NB-1:0]         ent_next;
  logic [KIND_BITS+3:0]  kind_ext;
  logic [KIND_BITS-1:0]  kind_st;
  logic [KIND_BITS+3:0]  lk_ext;
  logic                  hit;

  tlr_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign ent_valid = rdata[0];
  assign ent_end   = rdata[1];
  assign ent_kind  = rdata[KIND_BITS+1:2];
  assign ent_next  = rdata[EW-1:KIND_BITS+2];
  assign kind_ext  = {{KIND_BITS{1'b0}}, q_cmd.kind};
  assign kind_st   = kind_ext[KIND_BITS-1:0];

  assign clearing = (state == S_CLEAR);
  assign q_pop    = (state == S_EVAL);
  assign re       = (state == S_IDLE) && q_valid;
  assign raddr    = {current_node, q_cmd.ch};

  always_comb begin
    current_node_next  = current_node;
    word_failed_next   = word_failed;
    last_end_mark_next = last_end_mark;
    last_kind_next     = last_kind;
    nodes_used_next    = nodes_used;
    we                 = 1'b0;
    waddr              = raddr;
    wdata              = {nodes_used[NB-1:0], kind_st, q_cmd.last, 1'b1};
    if (state == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else if (state == S_EVAL && !word_failed) begin
      priority if (ent_valid) begin
        if (q_cmd.op == OP_DETECT) begin
          last_end_mark_next = ent_end;
          last_kind_next     = ent_kind;
        end
        current_node_next = ent_next;
      end else if (q_cmd.op == OP_DETECT) begin
        word_failed_next = 1'b1;
      end else if (nodes_used != NodesMax) begin
        we                = 1'b1;
        current_node_next = nodes_used[NB-1:0];
        nodes_used_next   = nodes_used + (NB + 1)'(1);
      end else begin
        word_failed_next = 1'b1;
      end
    end
  end

  assign hit    = !word_failed_next && last_end_mark_next;
  assign lk_ext = {4'b0000, last_kind_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      nodes_used    <= (NB + 1)'(1);
      current_node  <= '0;
      word_failed   <= 1'b0;
      last_end_mark <= 1'b0;
      last_kind     <= '0;
      res           <= '0;
    end else begin
      res.done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LastAddr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          state      <= S_IDLE;
          nodes_used <= nodes_used_next;
          if (q_cmd.last) begin
            res.done <= 1'b1;
            if (q_cmd.op == OP_DETECT) begin
              res.matched     <= hit;
              res.result_kind <= hit ? lk_ext[KIND_W-1:0] : '0;
              res.store_full  <= 1'b0;
            end else begin
              res.matched     <= 1'b0;
              res.result_kind <= '0;
              res.store_full  <= word_failed_next;
            end
            current_node  <= '0;
            word_failed   <= 1'b0;
            last_end_mark <= 1'b0;
            last_kind     <= '0;
          end else begin
            current_node  <= current_node_next;
            word_failed   <= word_failed_next;
            last_end_mark <= last_end_mark_next;
            last_kind     <= last_kind_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/tlr_checker.sv
// ----------------------------------------------------------------------------
// tlr_checker
// Port-level checks for the trie lexeme recogniser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tlr_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       busy,
  input wire logic                       done,
  input wire logic                       matched,
  input wire logic [tlr_pkg::KIND_W-1:0] result_kind,
  input wire logic                       store_full
);

  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  a_no_back_to_back_results: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("results in consecutive cycles");

  a_match_excludes_full: assert property (@(posedge clk) disable iff (rst)
    done |-> !(matched && store_full))
    else $error("match and store full together");

  a_kind_only_on_match: assert property (@(posedge clk) disable iff (rst)
    (done && !matched) |-> (result_kind == '0))
    else $error("kind reported without a match");

endmodule

bind trie_lexeme_recognizer tlr_checker u_tlr_checker (
  .clk        (clk),
  .rst        (rst),
  .busy       (busy),
  .done       (done),
  .matched    (matched),
  .result_kind(result_kind),
  .store_full (store_full)
);

`default_nettype wire
